### design/cpt_pkg.sv
// ----------------------------------------------------------------------------
// Clarke / Park transform package
// Operation codes, fixed-point coefficients and pipeline constants used by
// the transform unit and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package cpt_pkg;

  // Operation selected by each request.
  typedef enum logic [1:0] {
    FUNC_CLARKE     = 2'd0,
    FUNC_INV_CLARKE = 2'd1,
    FUNC_PARK       = 2'd2,
    FUNC_INV_PARK   = 2'd3
  } func_e;

  // Fraction bits of the Clarke coefficients.
  localparam int Q30_FRAC = 30;

  // Width of the coefficient operand of every multiplier.
  localparam int COEF_WIDTH = 32;

  // Clarke and inverse Clarke coefficients in Q30.
  localparam logic signed [COEF_WIDTH-1:0] Q30_ONE_THIRD  = 32'sd357913941;
  localparam logic signed [COEF_WIDTH-1:0] Q30_INV_SQRT3  = 32'sd619925131;
  localparam logic signed [COEF_WIDTH-1:0] Q30_HALF_SQRT3 = 32'sd929887697;

  // Quarter turn in Q30 radians and the series length used to fill the ROM.
  localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
  localparam int TAYLOR_TERMS = 12;

  // Cycles from an accepted request to its result strobe.
  localparam int LATENCY = 5;

endpackage

`default_nettype wire

### design/clarke_park_transform_unit.sv
// ----------------------------------------------------------------------------
// Clarke / Park transform unit
// Pipelined frame transforms on Q1.15 motor currents: Clarke, inverse Clarke,
// Park and inverse Park, with a quarter-wave sine ROM and saturating outputs.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                        Handshake
//  --------  -------------------------------------------  -------------------
//  request   func_i, sample_a_i, sample_b_i, sample_c_i,  start high, busy low
//            angle_i
//  result    result_a_o, result_b_o, result_c_o,          done_o high for one
//            clipped_o                                    cycle
//
//  One request is taken every clock; busy stays low.
//  Each result passes through the five register stages: input, angle
//  decode, sine ROM read, multiply, round.
//  Reset clears the stage valid bits, so requests in flight are dropped.
//  The receiver cannot stall; a result is shown for its single cycle only.
//
`default_nettype none

module clarke_park_transform_unit #(
  parameter int SAMPLE_WIDTH     = 16,
  parameter int ANGLE_WIDTH      = 16,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [1:0]                     func_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_a_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_b_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_c_i,
  input  wire logic [ANGLE_WIDTH-1:0]         angle_i,
  output logic                                done_o,
  output logic signed [SAMPLE_WIDTH-1:0]      result_a_o,
  output logic signed [SAMPLE_WIDTH-1:0]      result_b_o,
  output logic signed [SAMPLE_WIDTH-1:0]      result_c_o,
  output logic                                clipped_o
);

  // Derived widths.
  localparam int IW    = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int MULW  = ANGLE_WIDTH + $clog2(4 * SINE_TABLE_DEPTH + 1);
  localparam int PHW   = MULW - ANGLE_WIDTH;
  localparam int PHW1  = PHW + 1;
  localparam int XW    = SAMPLE_WIDTH + 2;
  localparam int PW    = XW + cpt_pkg::COEF_WIDTH;
  localparam int SUMW  = PW + 2;
  localparam int PFRAC = SAMPLE_WIDTH - 1;

  typedef logic signed [SAMPLE_WIDTH-1:0]            sample_t;
  typedef logic [SINE_TABLE_DEPTH:0][SAMPLE_WIDTH-1:0] rom_t;
  typedef logic signed [XW-1:0]                      xop_t;
  typedef logic signed [cpt_pkg::COEF_WIDTH-1:0]     yop_t;
  typedef logic signed [PW-1:0]                      prod_t;
  typedef logic signed [SUMW-1:0]                    sum_t;

  typedef struct packed {
    logic          neg;
    logic [IW-1:0] idx;
  } rom_sel_t;

  typedef struct packed {
    logic    clip;
    sample_t val;
  } res_t;

  // Phase constants.
  localparam logic [MULW-1:0] TURN_MUL  = MULW'(4 * SINE_TABLE_DEPTH);
  localparam logic [PHW1-1:0] PH_Q1     = PHW1'(SINE_TABLE_DEPTH);
  localparam logic [PHW1-1:0] PH_Q2     = PHW1'(2 * SINE_TABLE_DEPTH);
  localparam logic [PHW1-1:0] PH_Q3     = PHW1'(3 * SINE_TABLE_DEPTH);
  localparam logic [PHW1-1:0] PH_TURN   = PHW1'(4 * SINE_TABLE_DEPTH);
  localparam logic [IW-1:0]   DEPTH_IDX = IW'(SINE_TABLE_DEPTH);

  // Rounding and saturation constants.
  localparam sum_t    HALF_Q30 = sum_t'(1) << (cpt_pkg::Q30_FRAC - 1);
  localparam sum_t    HALF_PRK = sum_t'(1) << (PFRAC - 1);
  localparam sample_t RES_MAX  = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam sample_t RES_MIN  = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam sum_t    SUM_MAX  = sum_t'(RES_MAX);
  localparam sum_t    SUM_MIN  = sum_t'(RES_MIN);

  // Fills the quarter-wave sine table from a Q30 Taylor series.
  function automatic rom_t build_sine_rom();
    rom_t               rom;
    logic [63:0]        th;
    logic [63:0]        th2;
    logic [63:0]        term;
    logic [63:0]        amp;
    logic [63:0]        v;
    logic signed [63:0] sum;
    rom = '0;
    amp = (64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      th = (64'(k) * cpt_pkg::Q30_HALF_PI + 64'(SINE_TABLE_DEPTH / 2))
           / 64'(SINE_TABLE_DEPTH);
      th2  = (th * th) >> cpt_pkg::Q30_FRAC;
      term = th;
      sum  = signed'(th);
      for (int n = 1; n <= cpt_pkg::TAYLOR_TERMS; n++) begin
        term = ((term * th2) >> cpt_pkg::Q30_FRAC) / 64'((2 * n) * (2 * n + 1));
        if (n[0]) begin
          sum = sum - signed'(term);
        end else begin
          sum = sum + signed'(term);
        end
      end
      if (sum < 0) begin
        sum = '0;
      end
      if (sum > (64'sd1 <<< cpt_pkg::Q30_FRAC)) begin
        sum = 64'sd1 <<< cpt_pkg::Q30_FRAC;
      end
      v = ($unsigned(sum) * amp + (64'd1 << (cpt_pkg::Q30_FRAC - 1)))
          >> cpt_pkg::Q30_FRAC;
      if (v > amp) begin
        v = amp;
      end
      rom[k] = v[SAMPLE_WIDTH-1:0];
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_sine_rom();

  // Maps a phase in [0, 4*depth) to a quarter-wave ROM address and sign.
  function automatic rom_sel_t rom_select(input logic [PHW1-1:0] ph);
    logic [1:0]      quad;
    logic [PHW1-1:0] off;
    rom_sel_t        sel;
    if (ph >= PH_Q3) begin
      quad = 2'd3;
      off  = ph - PH_Q3;
    end else if (ph >= PH_Q2) begin
      quad = 2'd2;
      off  = ph - PH_Q2;
    end else if (ph >= PH_Q1) begin
      quad = 2'd1;
      off  = ph - PH_Q1;
    end else begin
      quad = 2'd0;
      off  = ph;
    end
    sel.neg = quad[1];
    sel.idx = quad[0] ? (DEPTH_IDX - off[IW-1:0]) : off[IW-1:0];
    return sel;
  endfunction

  // Rounds half up by the given fraction and saturates to the sample range.
  function automatic res_t round_sat(input sum_t v, input logic q30);
    sum_t t;
    sum_t s;
    res_t r;
    if (q30) begin
      t = v + HALF_Q30;
      s = t >>> cpt_pkg::Q30_FRAC;
    end else begin
      t = v + HALF_PRK;
      s = t >>> PFRAC;
    end
    r.clip = 1'b0;
    r.val  = s[SAMPLE_WIDTH-1:0];
    if (s > SUM_MAX) begin
      r.clip = 1'b1;
      r.val  = RES_MAX;
    end else if (s < SUM_MIN) begin
      r.clip = 1'b1;
      r.val  = RES_MIN;
    end
    return r;
  endfunction

  // The pipeline takes a request in every cycle.
  assign busy = 1'b0;

  // Stage 1: input register.
  logic                       s1_valid_q;
  cpt_pkg::func_e             s1_func_q;
  sample_t                    s1_a_q, s1_b_q, s1_c_q;
  logic [ANGLE_WIDTH-1:0]     s1_angle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_func_q  <= cpt_pkg::func_e'(func_i);
    s1_a_q     <= sample_a_i;
    s1_b_q     <= sample_b_i;
    s1_c_q     <= sample_c_i;
    s1_angle_q <= angle_i;
  end

  // Stage 2: angle to sine and cosine ROM addresses.
  logic [MULW-1:0]  phase_full;
  logic [PHW1-1:0]  phase_sin;
  logic [PHW1-1:0]  phase_cos_raw;
  logic [PHW1-1:0]  phase_cos;
  rom_sel_t         sin_sel_d, cos_sel_d;

  always_comb begin
    phase_full    = MULW'(s1_angle_q) * TURN_MUL;
    phase_sin     = {1'b0, phase_full[MULW-1:ANGLE_WIDTH]};
    phase_cos_raw = phase_sin + PH_Q1;
    phase_cos     = (phase_cos_raw >= PH_TURN) ? (phase_cos_raw - PH_TURN)
                                                : phase_cos_raw;
    sin_sel_d     = rom_select(phase_sin);
    cos_sel_d     = rom_select(phase_cos);
  end

  logic           s2_valid_q;
  cpt_pkg::func_e s2_func_q;
  sample_t        s2_a_q, s2_b_q, s2_c_q;
  rom_sel_t       s2_sin_sel_q, s2_cos_sel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_func_q    <= s1_func_q;
    s2_a_q       <= s1_a_q;
    s2_b_q       <= s1_b_q;
    s2_c_q       <= s1_c_q;
    s2_sin_sel_q <= sin_sel_d;
    s2_cos_sel_q <= cos_sel_d;
  end

  // Stage 3: registered sine ROM reads, one for sine and one for cosine.
  logic                    s3_valid_q;
  cpt_pkg::func_e          s3_func_q;
  sample_t                 s3_a_q, s3_b_q, s3_c_q;
  logic [SAMPLE_WIDTH-1:0] s3_sin_mag_q, s3_cos_mag_q;
  logic                    s3_sin_neg_q, s3_cos_neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_func_q    <= s2_func_q;
    s3_a_q       <= s2_a_q;
    s3_b_q       <= s2_b_q;
    s3_c_q       <= s2_c_q;
    s3_sin_mag_q <= SINE_ROM[s2_sin_sel_q.idx];
    s3_cos_mag_q <= SINE_ROM[s2_cos_sel_q.idx];
    s3_sin_neg_q <= s2_sin_sel_q.neg;
    s3_cos_neg_q <= s2_cos_sel_q.neg;
  end

  // Stage 4: operand selection and four shared multipliers.
  sample_t sn, cs;
  xop_t    x0, x1, x2, x3;
  yop_t    y0, y1, y2, y3;
  prod_t   m0_d, m1_d, m2_d, m3_d;

  always_comb begin
    sn = s3_sin_neg_q ? -signed'(s3_sin_mag_q) : signed'(s3_sin_mag_q);
    cs = s3_cos_neg_q ? -signed'(s3_cos_mag_q) : signed'(s3_cos_mag_q);
    x0 = '0;
    x1 = '0;
    x2 = '0;
    x3 = '0;
    y0 = '0;
    y1 = '0;
    y2 = '0;
    y3 = '0;
    case (s3_func_q)
      cpt_pkg::FUNC_CLARKE: begin
        x0 = (XW'(s3_a_q) + XW'(s3_a_q)) - XW'(s3_b_q) - XW'(s3_c_q);
        y0 = cpt_pkg::Q30_ONE_THIRD;
        x1 = XW'(s3_b_q) - XW'(s3_c_q);
        y1 = cpt_pkg::Q30_INV_SQRT3;
      end
      cpt_pkg::FUNC_INV_CLARKE: begin
        x0 = XW'(s3_b_q);
        y0 = cpt_pkg::Q30_HALF_SQRT3;
      end
      default: begin
        x0 = XW'(s3_a_q);
        y0 = cpt_pkg::COEF_WIDTH'(cs);
        x1 = XW'(s3_b_q);
        y1 = cpt_pkg::COEF_WIDTH'(sn);
        x2 = XW'(s3_b_q);
        y2 = cpt_pkg::COEF_WIDTH'(cs);
        x3 = XW'(s3_a_q);
        y3 = cpt_pkg::COEF_WIDTH'(sn);
      end
    endcase
    m0_d = PW'(x0) * PW'(y0);
    m1_d = PW'(x1) * PW'(y1);
    m2_d = PW'(x2) * PW'(y2);
    m3_d = PW'(x3) * PW'(y3);
  end

  logic           s4_valid_q;
  cpt_pkg::func_e s4_func_q;
  sample_t        s4_a_q;
  prod_t          m0_q, m1_q, m2_q, m3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_func_q <= s3_func_q;
    s4_a_q    <= s3_a_q;
    m0_q      <= m0_d;
    m1_q      <= m1_d;
    m2_q      <= m2_d;
    m3_q      <= m3_d;
  end

  // Stage 5: sums, rounding and saturation into the result register.
  sum_t    base;
  sum_t    sum_a, sum_b, sum_c;
  logic    use_q30;
  logic    is_inv_clarke;
  res_t    rr_a, rr_b, rr_c;
  sample_t result_a_d, result_b_d, result_c_d;
  logic    clipped_d;

  always_comb begin
    base          = -(sum_t'(s4_a_q) <<< (cpt_pkg::Q30_FRAC - 1));
    is_inv_clarke = (s4_func_q == cpt_pkg::FUNC_INV_CLARKE);
    use_q30       = (s4_func_q == cpt_pkg::FUNC_CLARKE) || is_inv_clarke;
    sum_a         = '0;
    sum_b         = '0;
    sum_c         = '0;
    case (s4_func_q)
      cpt_pkg::FUNC_CLARKE: begin
        sum_a = sum_t'(m0_q);
        sum_b = sum_t'(m1_q);
      end
      cpt_pkg::FUNC_INV_CLARKE: begin
        sum_b = base + sum_t'(m0_q);
        sum_c = base - sum_t'(m0_q);
      end
      cpt_pkg::FUNC_PARK: begin
        sum_a = sum_t'(m0_q) + sum_t'(m1_q);
        sum_b = sum_t'(m2_q) - sum_t'(m3_q);
      end
      default: begin
        sum_a = sum_t'(m0_q) - sum_t'(m1_q);
        sum_b = sum_t'(m3_q) + sum_t'(m2_q);
      end
    endcase
    rr_a = round_sat(sum_a, use_q30);
    rr_b = round_sat(sum_b, use_q30);
    rr_c = round_sat(sum_c, use_q30);

    // Inverse Clarke passes phase a through; only it drives phase c.
    result_a_d = is_inv_clarke ? s4_a_q : rr_a.val;
    result_b_d = rr_b.val;
    result_c_d = is_inv_clarke ? rr_c.val : '0;
    clipped_d  = (!is_inv_clarke && rr_a.clip) || rr_b.clip
                 || (is_inv_clarke && rr_c.clip);
  end

  logic    done_q;
  sample_t result_a_q, result_b_q, result_c_q;
  logic    clipped_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    result_a_q <= result_a_d;
    result_b_q <= result_b_d;
    result_c_q <= result_c_d;
    clipped_q  <= clipped_d;
  end

  assign done_o     = done_q;
  assign result_a_o = result_a_q;
  assign result_b_o = result_b_q;
  assign result_c_o = result_c_q;
  assign clipped_o  = clipped_q;

endmodule

`default_nettype wire

### design/cpt_checker.sv
// ----------------------------------------------------------------------------
// Clarke / Park transform checker
// Port-level assertions on request-to-result timing and result contents,
// bound to the transform unit.
// ----------------------------------------------------------------------------
`default_nettype none

module cpt_checker #(
  parameter int SAMPLE_WIDTH = 16
) (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           start,
  input wire logic                           busy,
  input wire logic [1:0]                     func_i,
  input wire logic signed [SAMPLE_WIDTH-1:0] sample_a_i,
  input wire logic                           done_o,
  input wire logic signed [SAMPLE_WIDTH-1:0] result_a_o,
  input wire logic signed [SAMPLE_WIDTH-1:0] result_b_o,
  input wire logic signed [SAMPLE_WIDTH-1:0] result_c_o,
  input wire logic                           clipped_o
);

  localparam logic signed [SAMPLE_WIDTH-1:0] RES_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] RES_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  // Every accepted request produces a result after the fixed latency.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(cpt_pkg::LATENCY) done_o)
  else $error("request did not produce a result after the pipeline latency");

  // No result strobe without a matching request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, cpt_pkg::LATENCY))
  else $error("result strobe without a matching request");

  // Inverse Clarke passes phase a through unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ($past(func_i, cpt_pkg::LATENCY) == cpt_pkg::FUNC_INV_CLARKE))
    |-> (result_a_o == $past(sample_a_i, cpt_pkg::LATENCY)))
  else $error("inverse Clarke phase a differs from alpha");

  // Phase c is zero for every operation except inverse Clarke.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ($past(func_i, cpt_pkg::LATENCY) != cpt_pkg::FUNC_INV_CLARKE))
    |-> (result_c_o == '0))
  else $error("unused result slot is not zero");

  // A clipped result leaves at least one output on a rail.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && clipped_o) |->
      ((result_a_o == RES_MAX) || (result_a_o == RES_MIN) ||
       (result_b_o == RES_MAX) || (result_b_o == RES_MIN) ||
       (result_c_o == RES_MAX) || (result_c_o == RES_MIN)))
  else $error("clipped flag set with no saturated output");

endmodule

bind clarke_park_transform_unit cpt_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_cpt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .func_i     (func_i),
  .sample_a_i (sample_a_i),
  .done_o     (done_o),
  .result_a_o (result_a_o),
  .result_b_o (result_b_o),
  .result_c_o (result_c_o),
  .clipped_o  (clipped_o)
);

`default_nettype wire
